### src/cse_pkg.sv
`timescale 1ns / 1ps

package cse_pkg;

    localparam int PIX_W        = 8;
    localparam int GRAD_W       = 11;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int IMG_W_W      = 12;
    localparam int IMG_H_W      = 13;
    localparam int ROW_W        = 12;
    localparam int DIM_MIN      = 3;
    localparam int HEIGHT_MAX   = 4096;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int WIN_EDGE     = 2;
    localparam int MAG_MAX      = 255;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     line_last;
        logic                     frame_last;
    } t_grad;

endpackage

### src/cse_front.sv
`timescale 1ns / 1ps

module cse_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cse_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [cse_pkg::PIX_W-1:0]       i_blue,
    input  logic [cse_pkg::PIX_W-1:0]       i_green,
    input  logic [cse_pkg::PIX_W-1:0]       i_red,
    input  logic [cse_pkg::QCNT_W-1:0]      i_q_count,
    output logic                            o_push,
    output cse_pkg::t_grad                  o_grad
);
    import cse_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
    localparam int OCC_W = QCNT_W + 1;

    logic [IMG_W_W-1:0] r_image_width;
    logic [IMG_H_W-1:0] r_image_height;

    logic [CW-1:0]      r_col;
    logic [ROW_W-1:0]   r_row;

    logic [WW-1:0]      w_ext;
    logic [WW-1:0]      w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic [WW-1:0]      col_inc;
    logic [IMG_H_W-1:0] row_inc;
    logic               line_end;
    logic               frame_end;
    logic               emit;
    logic               accept;
    logic [PIX_W-1:0]   gray;
    logic [OCC_W-1:0]   occ;

    // stage 1: accepted pixel plus registered line store reads
    logic               r_v1;
    logic               r_e1;
    logic               r_le1;
    logic               r_fe1;
    logic [PIX_W-1:0]   r_gray1;
    logic [CW-1:0]      r_col1;
    logic [PIX_W-1:0]   r_up_rd;
    logic [PIX_W-1:0]   r_mid_rd;

    logic [PIX_W-1:0]   mem_up  [MAX_WIDTH];
    logic [PIX_W-1:0]   mem_mid [MAX_WIDTH];

    logic [PIX_W-1:0]   r_win [9];
    logic [PIX_W-1:0]   n_win [9];

    logic [GRAD_W-1:0]  gx_pos;
    logic [GRAD_W-1:0]  gx_neg;
    logic [GRAD_W-1:0]  gy_pos;
    logic [GRAD_W-1:0]  gy_neg;

    logic               r_v2;
    t_grad              r_grad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMG_W_W'(WIDTH_RESET);
            r_image_height <= IMG_H_W'(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[IMG_H_W-1:0];
            endcase
        end
    end

    always_comb begin
        w_ext = WW'(r_image_width);
        if (w_ext < WW'(DIM_MIN)) begin
            w_eff = WW'(DIM_MIN);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (r_image_height < IMG_H_W'(DIM_MIN)) begin
            h_eff = IMG_H_W'(DIM_MIN);
        end else if (r_image_height > IMG_H_W'(HEIGHT_MAX)) begin
            h_eff = IMG_H_W'(HEIGHT_MAX);
        end else begin
            h_eff = r_image_height;
        end
    end

    assign col_inc   = WW'(r_col) + WW'(1);
    assign row_inc   = IMG_H_W'(r_row) + IMG_H_W'(1);
    assign line_end  = col_inc >= w_eff;
    assign frame_end = line_end && (row_inc >= h_eff);
    assign emit      = (r_row >= ROW_W'(WIN_EDGE)) && (r_col >= CW'(WIN_EDGE));

    assign gray = PIX_W'(i_blue >> 3) + PIX_W'(i_green >> 1) + PIX_W'(i_red >> 2);

    // every result still in the pipe holds a queue slot in advance
    assign occ     = OCC_W'(i_q_count) + OCC_W'(r_v1 & r_e1) + OCC_W'(r_v2);
    assign o_ready = occ < OCC_W'(QUEUE_DEPTH);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (line_end) begin
                r_col <= '0;
                if (frame_end) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e1    <= emit;
            r_le1   <= line_end;
            r_fe1   <= frame_end;
            r_gray1 <= gray;
            r_col1  <= r_col;
        end
    end

    // consecutive pixels never share a column, so the read never meets the pending write
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_rd  <= mem_up[r_col];
            r_mid_rd <= mem_mid[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            mem_up[r_col1]  <= r_mid_rd;
            mem_mid[r_col1] <= r_gray1;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k*3]     = r_win[k*3+1];
            n_win[k*3 + 1] = r_win[k*3+2];
        end
        n_win[2] = r_up_rd;
        n_win[5] = r_mid_rd;
        n_win[8] = r_gray1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_v1) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    always_comb begin
        gx_pos = GRAD_W'(n_win[2]) + (GRAD_W'(n_win[5]) << 1) + GRAD_W'(n_win[8]);
        gx_neg = GRAD_W'(n_win[0]) + (GRAD_W'(n_win[3]) << 1) + GRAD_W'(n_win[6]);
        gy_pos = GRAD_W'(n_win[6]) + (GRAD_W'(n_win[7]) << 1) + GRAD_W'(n_win[8]);
        gy_neg = GRAD_W'(n_win[0]) + (GRAD_W'(n_win[1]) << 1) + GRAD_W'(n_win[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1 & r_e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_grad.gx         <= $signed(gx_pos - gx_neg);
            r_grad.gy         <= $signed(gy_pos - gy_neg);
            r_grad.line_last  <= r_le1;
            r_grad.frame_last <= r_fe1;
        end
    end

    assign o_push = r_v2;
    assign o_grad = r_grad;

endmodule

### src/cse_queue.sv
`timescale 1ns / 1ps

module cse_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  cse_pkg::t_grad              i_data,
    input  logic                        i_pop,
    output logic                        o_valid,
    output cse_pkg::t_grad              o_data,
    output logic [cse_pkg::QCNT_W-1:0]  o_count
);
    import cse_pkg::*;

    t_grad             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (pop_ok) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !pop_ok) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && pop_ok) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

### src/cse_back.sv
`timescale 1ns / 1ps

module cse_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  cse_pkg::t_grad              i_grad,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cse_pkg::PIX_W-1:0]   o_edge_magnitude,
    output logic                        o_line_last,
    output logic                        o_frame_last
);
    import cse_pkg::*;

    logic [GRAD_W-1:0] abs_x;
    logic [GRAD_W-1:0] abs_y;
    logic [GRAD_W-1:0] mag;
    logic [PIX_W-1:0]  mag_sat;
    logic              r_valid;
    logic [PIX_W-1:0]  r_mag;
    logic              r_line_last;
    logic              r_frame_last;

    always_comb begin
        abs_x   = i_grad.gx[GRAD_W-1] ? GRAD_W'(-i_grad.gx) : GRAD_W'(i_grad.gx);
        abs_y   = i_grad.gy[GRAD_W-1] ? GRAD_W'(-i_grad.gy) : GRAD_W'(i_grad.gy);
        mag     = abs_x + abs_y;
        mag_sat = (mag > GRAD_W'(MAG_MAX)) ? PIX_W'(MAG_MAX) : mag[PIX_W-1:0];
    end

    assign o_pop = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mag        <= mag_sat;
            r_line_last  <= i_grad.line_last;
            r_frame_last <= i_grad.frame_last;
        end
    end

    assign o_valid          = r_valid;
    assign o_edge_magnitude = r_mag;
    assign o_line_last      = r_line_last;
    assign o_frame_last     = r_frame_last;

endmodule

### src/color_to_sobel_edge_stream.sv
`timescale 1ns / 1ps
// a result is valid after stage 1, the gradient register, the queue and the output register
// throughput: one pixel per cycle while o_ready is high; the line stores are read on accept and written from stage 1
// the input stalls only when the 4-entry gradient queue plus results in flight fill up
// reset (synchronous, active low) clears counters, window and queue; width 640, height 480
// line store contents are not cleared by reset

module color_to_sobel_edge_stream #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cse_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [cse_pkg::PIX_W-1:0]       i_blue,
    input  logic [cse_pkg::PIX_W-1:0]       i_green,
    input  logic [cse_pkg::PIX_W-1:0]       i_red,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [cse_pkg::PIX_W-1:0]       o_edge_magnitude,
    output logic                            o_line_last,
    output logic                            o_frame_last
);
    import cse_pkg::*;

    logic              push;
    t_grad             push_grad;
    logic              q_valid;
    t_grad             q_grad;
    logic [QCNT_W-1:0] q_count;
    logic              pop;

    cse_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_grad      (push_grad)
    );

    cse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_grad),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_grad),
        .o_count (q_count)
    );

    cse_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_grad           (q_grad),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_edge_magnitude (o_edge_magnitude),
        .o_line_last      (o_line_last),
        .o_frame_last     (o_frame_last)
    );

endmodule
